// ===== sv/dptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt_pkg
// Shared constants, types and helper functions of the depth pixel
// threshold and trim block.
// ----------------------------------------------------------------------------
package dptt_pkg;

	// Frame geometry limits.
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int FW_W       = 12;
	localparam int WCMP_W     = ((COL_W + 1 > FW_W) ? COL_W + 1 : FW_W) + 1;

	// Configuration port.
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT   = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT  = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_BOX_X_LOW   = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_BOX_X_HIGH  = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_BOX_Y_LOW   = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_BOX_Y_HIGH  = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_MODE_FLAGS  = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = REG_IDX_W'(7);

	// Bit positions in mode_flags.
	localparam int MODE_WHITEN = 0;
	localparam int MODE_TRIM   = 1;
	localparam int MODE_INVERT = 2;
	localparam int MODE_USER   = 3;

	// Coordinate arithmetic widths.
	localparam int DEPTH_W = 16;
	localparam int FAC_BASE = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int FAC_W   = ((FAC_BASE > 10) ? FAC_BASE : 10) + 1;
	localparam int MAG_W   = FAC_W + DEPTH_W;
	localparam int K_W     = 24;
	localparam int PROD_W  = MAG_W + K_W;
	localparam int CMP_W   = ((PROD_W > 50) ? PROD_W : 50) + 2;

	// Scale factors of the x and y axes (Q23 and Q24) and their divisors.
	localparam logic [K_W-1:0] KX = K_W'(9323658);
	localparam logic [K_W-1:0] KY = K_W'(13985487);
	localparam logic signed [CMP_W-1:0] X_DEN = CMP_W'(40960);
	localparam logic signed [CMP_W-1:0] Y_DEN = CMP_W'(61440);

	// Queue between front and back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic        [15:0]     low_limit;
		logic        [15:0]     high_limit;
		logic signed [15:0]     box_x_low;
		logic signed [15:0]     box_x_high;
		logic signed [15:0]     box_y_low;
		logic signed [15:0]     box_y_high;
		logic        [3:0]      mode_flags;
		logic        [FW_W-1:0] frame_width;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       hi;
		logic [7:0]       lo;
		logic [7:0]       ub;
		logic [7:0]       al;
		logic             fail;
		logic             xneg;
		logic [FAC_W-1:0] xmag;
		logic             yneg;
		logic [FAC_W-1:0] ymag;
	} entry_t;

	// Bound * 2^18 * 40960, that is bound * 5 * 2^31.
	function automatic logic signed [CMP_W-1:0] thr_x(input logic signed [15:0] b);
		logic signed [CMP_W-1:0] e;
		e = {{(CMP_W-16){b[15]}}, b};
		return (e <<< 33) + (e <<< 31);
	endfunction

	// Bound * 2^18 * 61440, that is bound * 15 * 2^30.
	function automatic logic signed [CMP_W-1:0] thr_y(input logic signed [15:0] b);
		logic signed [CMP_W-1:0] e;
		e = {{(CMP_W-16){b[15]}}, b};
		return (e <<< 34) - (e <<< 30);
	endfunction

endpackage

// ===== sv/dptt_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt interfaces
// Pixel input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface dptt_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] depth_high;
	logic [7:0] depth_low;
	logic [7:0] user_byte;
	logic [7:0] alpha_in;
	logic       frame_start;

	modport source (output valid, depth_high, depth_low, user_byte, alpha_in, frame_start,
		input ready);
	modport sink (input valid, depth_high, depth_low, user_byte, alpha_in, frame_start,
		output ready);
endinterface

interface dptt_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface dptt_cfg_if import dptt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dptt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt_front
// Accepts pixels, tracks column and row, applies the depth limit test and
// forms the signed coordinate factors for the back end.
// ----------------------------------------------------------------------------
module dptt_front import dptt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	dptt_pix_in_if.sink    pix_in,
	input  cfg_t           cfg,
	input  logic           fifo_full,
	output logic           push,
	output entry_t         push_data
);

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_use;
	logic [ROW_W-1:0]   row_use;
	logic [WCMP_W-1:0]  width_eff;
	logic [WCMP_W-1:0]  col_inc;
	logic               wrap;
	logic [ROW_W-1:0]   row_inc;
	logic [15:0]        depth;
	logic [7:0]         mark;
	logic [FAC_W+1:0]   xu;
	logic [FAC_W+1:0]   xn;
	logic [FAC_W+1:0]   yu;
	logic [FAC_W+1:0]   yn;

	assign pix_in.ready = !fifo_full;
	assign push         = pix_in.valid && !fifo_full;

	// A frame start clears the counters before this pixel uses them.
	assign col_use = pix_in.frame_start ? '0 : col_q;
	assign row_use = pix_in.frame_start ? '0 : row_q;

	always_comb begin
		if (cfg.frame_width == '0) begin
			width_eff = WCMP_W'(1);
		end else if (WCMP_W'(cfg.frame_width) > WCMP_W'(MAX_WIDTH)) begin
			width_eff = WCMP_W'(MAX_WIDTH);
		end else begin
			width_eff = WCMP_W'(cfg.frame_width);
		end
	end

	assign col_inc = WCMP_W'(col_use) + WCMP_W'(1);
	assign wrap    = col_inc >= width_eff;
	assign row_inc = (row_use == ROW_W'(MAX_HEIGHT - 1)) ? '0 : row_use + ROW_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			col_q <= wrap ? '0 : col_inc[COL_W-1:0];
			row_q <= wrap ? row_inc : row_use;
		end
	end

	assign depth = {pix_in.depth_high, pix_in.depth_low};
	assign mark  = cfg.mode_flags[MODE_USER] ? pix_in.user_byte : 8'd0;

	// x factor 2*(col+1) - 640, y factor 480 - 2*(row+1), split into sign and size.
	assign xu = (FAC_W+2)'({col_use, 1'b0}) + (FAC_W+2)'(2) - (FAC_W+2)'(640);
	assign xn = -xu;
	assign yu = (FAC_W+2)'(478) - (FAC_W+2)'({row_use, 1'b0});
	assign yn = -yu;

	always_comb begin
		push_data.hi   = pix_in.depth_high;
		push_data.lo   = pix_in.depth_low;
		push_data.ub   = pix_in.user_byte;
		push_data.al   = pix_in.alpha_in;
		push_data.fail = (depth < cfg.low_limit) ||
			((depth > cfg.high_limit) && (mark == 8'd0));
		push_data.xneg = xu[FAC_W+1];
		push_data.xmag = xu[FAC_W+1] ? xn[FAC_W-1:0] : xu[FAC_W-1:0];
		push_data.yneg = yu[FAC_W+1];
		push_data.ymag = yu[FAC_W+1] ? yn[FAC_W-1:0] : yu[FAC_W-1:0];
	end

endmodule

// ===== sv/dptt_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt_fifo
// Short queue of classified pixels between the front and the back end.
// ----------------------------------------------------------------------------
module dptt_fifo import dptt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output entry_t pop_data
);

	entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full     = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue holds more items than it has entries");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

endmodule

// ===== sv/dptt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptt_back
// Three-stage pipeline: depth product, scale product with bound setup, and
// the box test that forms the output pixel in the output register.
// ----------------------------------------------------------------------------
module dptt_back import dptt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          fifo_empty,
	input  entry_t        fifo_data,
	output logic          fifo_pop,
	dptt_pix_out_if.source pix_out
);

	logic                     en;

	logic                     v_s1;
	logic [31:0]              px_s1;
	logic                     fail_s1;
	logic                     xneg_s1;
	logic                     yneg_s1;
	logic [MAG_W-1:0]         xm_s1;
	logic [MAG_W-1:0]         ym_s1;

	logic                     v_s2;
	logic [31:0]              px_s2;
	logic                     fail_s2;
	logic                     xneg_s2;
	logic                     yneg_s2;
	logic [PROD_W-1:0]        mx_s2;
	logic [PROD_W-1:0]        my_s2;
	logic signed [CMP_W-1:0]  bxh_s2;
	logic signed [CMP_W-1:0]  bxl_s2;
	logic signed [CMP_W-1:0]  byh_s2;
	logic signed [CMP_W-1:0]  byl_s2;

	logic signed [CMP_W-1:0]  thxh;
	logic signed [CMP_W-1:0]  thxl;
	logic signed [CMP_W-1:0]  thyh;
	logic signed [CMP_W-1:0]  thyl;
	logic signed [CMP_W-1:0]  mx;
	logic signed [CMP_W-1:0]  my;
	logic                     in_x;
	logic                     in_y;
	logic [7:0]               fill_fail;
	logic [7:0]               fill_white;
	logic [31:0]              res;

	logic                     out_v_q;
	logic [31:0]              out_q;

	// The whole pipeline moves when the output register is free or being taken.
	assign en       = !out_v_q || pix_out.ready;
	assign fifo_pop = en && !fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= !fifo_empty;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	// Stage 1: |factor| * depth.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= {fifo_data.hi, fifo_data.lo, fifo_data.ub, fifo_data.al};
			fail_s1 <= fifo_data.fail;
			xneg_s1 <= fifo_data.xneg;
			yneg_s1 <= fifo_data.yneg;
			xm_s1   <= MAG_W'(fifo_data.xmag) * MAG_W'({fifo_data.hi, fifo_data.lo});
			ym_s1   <= MAG_W'(fifo_data.ymag) * MAG_W'({fifo_data.hi, fifo_data.lo});
		end
	end

	// Bounds scaled by 2^18 and by the divisor; stage 2 folds them for the sign of the factor.
	assign thxh = thr_x(cfg.box_x_high);
	assign thxl = thr_x(cfg.box_x_low);
	assign thyh = thr_y(cfg.box_y_high);
	assign thyl = thr_y(cfg.box_y_low);

	// Stage 2: scale product and per-item compare bounds.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s2   <= px_s1;
			fail_s2 <= fail_s1;
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
			mx_s2   <= PROD_W'(xm_s1) * PROD_W'(KX);
			my_s2   <= PROD_W'(ym_s1) * PROD_W'(KY);
			bxh_s2  <= xneg_s1 ? X_DEN - thxh : thxh;
			bxl_s2  <= xneg_s1 ? -thxl : thxl + X_DEN;
			byh_s2  <= yneg_s1 ? Y_DEN - thyh : thyh;
			byl_s2  <= yneg_s1 ? -thyl : thyl + Y_DEN;
		end
	end

	// Stage 3: strict box test on the truncated quotient, done on the product.
	assign mx = $signed({{(CMP_W-PROD_W){1'b0}}, mx_s2});
	assign my = $signed({{(CMP_W-PROD_W){1'b0}}, my_s2});
	assign in_x = xneg_s2 ? ((mx >= bxh_s2) && (mx < bxl_s2)) :
		((mx < bxh_s2) && (mx >= bxl_s2));
	assign in_y = yneg_s2 ? ((my >= byh_s2) && (my < byl_s2)) :
		((my < byh_s2) && (my >= byl_s2));

	assign fill_fail  = cfg.mode_flags[MODE_INVERT] ? 8'hFF : 8'h00;
	assign fill_white = cfg.mode_flags[MODE_INVERT] ? 8'h00 : 8'hFF;

	always_comb begin
		if (fail_s2) begin
			res = {4{fill_fail}};
		end else if (cfg.mode_flags[MODE_TRIM] && !(in_x && in_y)) begin
			res = '0;
		end else if (cfg.mode_flags[MODE_WHITEN]) begin
			res = {4{fill_white}};
		end else begin
			res = px_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	assign pix_out.valid     = out_v_q;
	assign pix_out.red_out   = out_q[31:24];
	assign pix_out.green_out = out_q[23:16];
	assign pix_out.blue_out  = out_q[15:8];
	assign pix_out.alpha_out = out_q[7:0];

	a_fail_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2 && fail_s2) |=>
		(out_q[31:24] == out_q[23:16] && out_q[23:16] == out_q[15:8] &&
		out_q[15:8] == out_q[7:0]))
		else $error("rejected pixel did not leave as a uniform fill");

	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s2))
		else $error("output became valid without an item in the last stage");

endmodule

// ===== sv/depth_pixel_threshold_trim.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_threshold_trim
// Depth limit test, box trim, whitening and inversion of a depth pixel stream.
// ----------------------------------------------------------------------------
// A pixel accepted at the input passes the queue, back-end stages 1 and 2
//   and the output register. Throughput: one pixel per cycle while the
//   output side does not stall, set by the fully pipelined back end.
// A four-entry queue lets the input keep flowing while the output stalls.
// Reset (arst_n low) clears the counters, the queue and all valid flags and loads
//   every configuration register with its default.
// ----------------------------------------------------------------------------
module depth_pixel_threshold_trim import dptt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	dptt_pix_in_if.sink    pix_in,
	dptt_pix_out_if.source pix_out,
	dptt_cfg_if.sink       cfg
);

	// Configuration registers. Writes are always taken; the register index
	// space is exactly the eight registers below.
	cfg_t   cfg_q;

	// Front to queue and queue to back.
	logic   push;
	entry_t push_data;
	logic   fifo_full;
	logic   fifo_pop;
	logic   fifo_empty;
	entry_t fifo_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_limit   <= 16'd10;
			cfg_q.high_limit  <= 16'd3000;
			cfg_q.box_x_low   <= -16'sd2000;
			cfg_q.box_x_high  <= 16'sd2000;
			cfg_q.box_y_low   <= -16'sd2000;
			cfg_q.box_y_high  <= 16'sd2000;
			cfg_q.mode_flags  <= 4'd0;
			cfg_q.frame_width <= FW_W'(640);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOW_LIMIT:   cfg_q.low_limit   <= cfg.data;
				REG_HIGH_LIMIT:  cfg_q.high_limit  <= cfg.data;
				REG_BOX_X_LOW:   cfg_q.box_x_low   <= cfg.data;
				REG_BOX_X_HIGH:  cfg_q.box_x_high  <= cfg.data;
				REG_BOX_Y_LOW:   cfg_q.box_y_low   <= cfg.data;
				REG_BOX_Y_HIGH:  cfg_q.box_y_high  <= cfg.data;
				REG_MODE_FLAGS:  cfg_q.mode_flags  <= cfg.data[3:0];
				REG_FRAME_WIDTH: cfg_q.frame_width <= cfg.data[FW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front end places each pixel in its frame, applies the depth limits
	// (a pixel above the high limit is still kept when it carries a user mark)
	// and splits the coordinate factors into sign and magnitude.
	dptt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.cfg       (cfg_q),
		.fifo_full (fifo_full),
		.push      (push),
		.push_data (push_data)
	);

	// The queue decouples the front from stalls at the output.
	dptt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.empty     (fifo_empty),
		.pop_data  (fifo_data)
	);

	// The back end computes the real position in Q18 fixed point. The truncated
	// quotient is never formed: the strict box bounds are scaled by the divisor
	// instead and compared against the raw product.
	dptt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fifo_empty (fifo_empty),
		.fifo_data  (fifo_data),
		.fifo_pop   (fifo_pop),
		.pix_out    (pix_out)
	);

endmodule

// ===== bench/tb_depth_pixel_threshold_trim.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_threshold_trim
// Self-checking bench for the depth pixel threshold and trim block. Pixels are
// pushed through the input channel under several idle and stall patterns, and
// every output pixel is compared with a bit-exact prediction that tracks the
// configuration and the column and row counters on its own.
// ----------------------------------------------------------------------------
import dptt_pkg::*;

typedef struct packed {
	logic [7:0] hi;
	logic [7:0] lo;
	logic [7:0] ub;
	logic [7:0] al;
	logic       fs;
} pixel_t;

typedef struct packed {
	logic [7:0] r;
	logic [7:0] g;
	logic [7:0] b;
	logic [7:0] a;
} rgba_t;

// Holds the shadow configuration, the shadow counters and the pixels that the
// block still owes us.
class pixel_ledger;
	localparam longint X_GAIN    = 9323658;
	localparam longint X_DIVISOR = 40960;
	localparam longint Y_GAIN    = 13985487;
	localparam longint Y_DIVISOR = 61440;
	localparam longint Q18_ONE   = 262144;

	cfg_t        regs;
	logic [10:0] col_cnt;
	logic [10:0] row_cnt;
	rgba_t       owed_pixels[$];
	int          mismatches;
	int          noted;
	int          checked;
	int          writes;

	function new();
		regs.low_limit   = 16'd10;
		regs.high_limit  = 16'd3000;
		regs.box_x_low   = -16'sd2000;
		regs.box_x_high  = 16'sd2000;
		regs.box_y_low   = -16'sd2000;
		regs.box_y_high  = 16'sd2000;
		regs.mode_flags  = 4'd0;
		regs.frame_width = FW_W'(640);
		col_cnt = '0;
		row_cnt = '0;
		mismatches = 0;
		noted = 0;
		checked = 0;
		writes = 0;
	endfunction

	function void load_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		writes++;
		case (idx)
			REG_LOW_LIMIT:   regs.low_limit   = data;
			REG_HIGH_LIMIT:  regs.high_limit  = data;
			REG_BOX_X_LOW:   regs.box_x_low   = data;
			REG_BOX_X_HIGH:  regs.box_x_high  = data;
			REG_BOX_Y_LOW:   regs.box_y_low   = data;
			REG_BOX_Y_HIGH:  regs.box_y_high  = data;
			REG_MODE_FLAGS:  regs.mode_flags  = data[3:0];
			REG_FRAME_WIDTH: regs.frame_width = data[FW_W-1:0];
			default: ;
		endcase
	endfunction

	// Signed product scaled by gain/divisor, truncated toward zero.
	function longint scale_trunc(longint n, longint gain, longint divisor);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = mag * gain / divisor;
		return (n < 0) ? -q : q;
	endfunction

	function rgba_t predict_pixel(pixel_t px);
		logic [15:0] depth;
		logic [7:0]  mark;
		logic [7:0]  fill_val;
		int          width;
		int          col;
		int          row;
		longint      nx;
		longint      ny;
		longint      rx;
		longint      ry;
		bit          in_box;
		bit          invert;
		rgba_t       res;
		depth  = {px.hi, px.lo};
		invert = regs.mode_flags[MODE_INVERT];
		mark   = regs.mode_flags[MODE_USER] ? px.ub : 8'd0;
		width  = int'(regs.frame_width);
		if (width == 0)
			width = 1;
		if (width > MAX_WIDTH)
			width = MAX_WIDTH;
		if (px.fs) begin
			col_cnt = '0;
			row_cnt = '0;
		end
		col = int'(col_cnt);
		row = int'(row_cnt);
		res = '{px.hi, px.lo, px.ub, px.al};
		if (depth < regs.low_limit || (depth > regs.high_limit && mark == 8'd0)) begin
			fill_val = invert ? 8'hFF : 8'h00;
			res = '{fill_val, fill_val, fill_val, fill_val};
		end else begin
			in_box = 1'b1;
			if (regs.mode_flags[MODE_TRIM]) begin
				nx = (2 * longint'(col + 1) - 640) * longint'(depth);
				ny = (480 - 2 * longint'(row + 1)) * longint'(depth);
				rx = scale_trunc(nx, X_GAIN, X_DIVISOR);
				ry = scale_trunc(ny, Y_GAIN, Y_DIVISOR);
				in_box = ry < longint'($signed(regs.box_y_high)) * Q18_ONE &&
					ry > longint'($signed(regs.box_y_low)) * Q18_ONE &&
					rx < longint'($signed(regs.box_x_high)) * Q18_ONE &&
					rx > longint'($signed(regs.box_x_low)) * Q18_ONE;
			end
			if (!in_box) begin
				res = '0;
			end else if (regs.mode_flags[MODE_WHITEN]) begin
				fill_val = invert ? 8'h00 : 8'hFF;
				res = '{fill_val, fill_val, fill_val, fill_val};
			end
		end
		col = col + 1;
		if (col >= width) begin
			col = 0;
			row = (row + 1) % MAX_HEIGHT;
		end
		col_cnt = col[10:0];
		row_cnt = row[10:0];
		return res;
	endfunction

	function void note_pixel(pixel_t px);
		noted++;
		owed_pixels.push_back(predict_pixel(px));
	endfunction

	function int pending();
		return owed_pixels.size();
	endfunction

	task report_mismatch(string what);
		mismatches++;
		if (mismatches <= 30)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	task check_pixel(rgba_t got);
		rgba_t      want;
		logic [7:0] want_b[4];
		logic [7:0] got_b[4];
		string      names[4];
		checked++;
		if (owed_pixels.size() == 0) begin
			report_mismatch($sformatf("output pixel %h with nothing outstanding", got));
			return;
		end
		want = owed_pixels.pop_front();
		want_b = '{want.r, want.g, want.b, want.a};
		got_b  = '{got.r, got.g, got.b, got.a};
		names  = '{"red", "green", "blue", "alpha"};
		for (int i = 0; i < 4; i++) begin
			if (got_b[i] !== want_b[i])
				report_mismatch($sformatf("pixel %0d %s: got %h, want %h",
					checked, names[i], got_b[i], want_b[i]));
		end
	endtask

	task report_leftovers();
		while (owed_pixels.size() != 0) begin
			void'(owed_pixels.pop_front());
			report_mismatch("output pixel never arrived");
		end
	endtask
endclass

module tb_depth_pixel_threshold_trim;

	// Length of the deliberate output hold-off that backs the block up.
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;

	dptt_pix_in_if  pix_in_if();
	dptt_pix_out_if pix_out_if();
	dptt_cfg_if     cfg_if();

	depth_pixel_threshold_trim dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_if),
		.pix_out (pix_out_if),
		.cfg     (cfg_if)
	);

	pixel_ledger ledger;

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int idle_pct;
	int stall_pct;
	// The main flow bumps hold_asked; the receiver process notices and runs
	// a hold-off of HOLD_CYCLES on its own count.
	int hold_asked;
	int hold_taken;
	int hold_left;
	int settings;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Watchdog: a run that does not finish in time is reported as a failure.
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: random back-pressure, plus the long hold-off on request.
	initial begin
		pix_out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_taken != hold_asked) begin
				hold_taken = hold_asked;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_out_if.ready <= 1'b0;
			end else begin
				pix_out_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Observe every handshake at the clock edge. Accepted pixels feed the
	// prediction, delivered pixels are checked, register writes update the
	// shadow configuration.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				ledger.load_reg(cfg_if.index, cfg_if.data);
			if (pix_in_if.valid && pix_in_if.ready)
				ledger.note_pixel('{pix_in_if.depth_high, pix_in_if.depth_low,
					pix_in_if.user_byte, pix_in_if.alpha_in, pix_in_if.frame_start});
			if (pix_out_if.valid && pix_out_if.ready)
				ledger.check_pixel('{pix_out_if.red_out, pix_out_if.green_out,
					pix_out_if.blue_out, pix_out_if.alpha_out});
		end
	end

	// Offers one pixel, after a random number of idle cycles, and returns at
	// the edge that takes it. Valid stays high so that back-to-back pixels
	// never see a low pulse.
	task automatic send_pixel(input logic fs, input logic [7:0] hi, input logic [7:0] lo,
		input logic [7:0] ub, input logic [7:0] al);
		while ($urandom_range(99) < idle_pct) begin
			pix_in_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in_if.valid       <= 1'b1;
		pix_in_if.depth_high  <= hi;
		pix_in_if.depth_low   <= lo;
		pix_in_if.user_byte   <= ub;
		pix_in_if.alpha_in    <= al;
		pix_in_if.frame_start <= fs;
		@(posedge clk);
		while (!pix_in_if.ready)
			@(posedge clk);
	endtask

	// Waits until every owed pixel has come back, then idles on so that the
	// pipeline is certainly empty before the configuration moves. The first
	// edge makes sure the pixel taken at the current edge has been noted.
	task automatic wait_drained();
		pix_in_if.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
	endtask

	// Writes the whole register file with raw 16-bit words; the block keeps
	// only the bits that each register has.
	task automatic apply_config(input logic [15:0] lo, input logic [15:0] hi,
		input logic [15:0] xl, input logic [15:0] xh, input logic [15:0] yl,
		input logic [15:0] yh, input logic [15:0] mode, input logic [15:0] width);
		wait_drained();
		write_reg(REG_LOW_LIMIT, lo);
		write_reg(REG_HIGH_LIMIT, hi);
		write_reg(REG_BOX_X_LOW, xl);
		write_reg(REG_BOX_X_HIGH, xh);
		write_reg(REG_BOX_Y_LOW, yl);
		write_reg(REG_BOX_Y_HIGH, yh);
		write_reg(REG_MODE_FLAGS, mode);
		write_reg(REG_FRAME_WIDTH, width);
		cfg_if.valid <= 1'b0;
		settings++;
	endtask

	task automatic set_idling(input int kind);
		case (kind)
			1: begin
				idle_pct = 69;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 69;
			end
			3: begin
				idle_pct = 8;
				stall_pct = 8;
			end
			default: begin
				idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// A random register setting. Limits and box edges land on their extremes
	// now and then; the frame width is mostly small so that rows turn over
	// often, with the odd zero or oversize width to exercise the clamps.
	task automatic random_config();
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] xl;
		logic [15:0] xh;
		logic [15:0] yl;
		logic [15:0] yh;
		logic [11:0] width;
		int          pick;
		pick = $urandom_range(99);
		lo = (pick < 15) ? 16'd0 : (pick < 20) ? 16'hFFFF : 16'($urandom_range(1500));
		pick = $urandom_range(99);
		hi = (pick < 10) ? 16'hFFFF : (pick < 15) ? 16'd0 : 16'($urandom_range(8000, 1500));
		xl = ($urandom_range(9) == 0) ? 16'h8000 : -16'($urandom_range(4000));
		xh = ($urandom_range(9) == 0) ? 16'h7FFF : 16'($urandom_range(4000));
		yl = ($urandom_range(9) == 0) ? 16'h8000 : -16'($urandom_range(4000));
		yh = ($urandom_range(9) == 0) ? 16'h7FFF : 16'($urandom_range(4000));
		pick = $urandom_range(99);
		if (pick < 40)
			width = 12'($urandom_range(16, 1));
		else if (pick < 70)
			width = 12'($urandom_range(700, 17));
		else if (pick < 80)
			width = 12'd640;
		else if (pick < 90)
			width = 12'd0;
		else
			width = 12'($urandom_range(4095, 2049));
		apply_config(lo, hi, xl, xh, yl, yh, {12'($urandom), 4'($urandom_range(15))},
			{4'($urandom), width});
	endtask

	// Random pixels. Depth is mostly in the range where limits and the box
	// actually decide, sometimes anywhere, and sometimes right on a limit.
	// A frame normally starts with the first pixel; with with_starts set a
	// few more frame starts fall at random.
	task automatic send_random(input int count, input bit with_starts);
		logic [15:0] depth;
		logic [7:0]  ub;
		logic        fs;
		int          pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 60)
				depth = 16'($urandom_range(6000));
			else if (pick < 85)
				depth = 16'($urandom);
			else if (pick < 92)
				depth = ledger.regs.low_limit + 16'($urandom_range(2)) - 16'd1;
			else
				depth = ledger.regs.high_limit + 16'($urandom_range(2)) - 16'd1;
			ub = ($urandom_range(99) < 40) ? 8'd0 : 8'($urandom);
			fs = (i == 0) || (with_starts && $urandom_range(39) == 0);
			send_pixel(fs, depth[15:8], depth[7:0], ub, 8'($urandom));
		end
	endtask

	initial begin
		int guard;
		ledger     = new();
		idle_pct   = 0;
		stall_pct  = 0;
		hold_asked = 0;
		hold_taken = 0;
		hold_left  = 0;
		settings   = 0;

		arst_n                <= 1'b0;
		cfg_if.valid          <= 1'b0;
		cfg_if.index          <= REG_LOW_LIMIT;
		cfg_if.data           <= '0;
		pix_in_if.valid       <= 1'b0;
		pix_in_if.depth_high  <= '0;
		pix_in_if.depth_low   <= '0;
		pix_in_if.user_byte   <= '0;
		pix_in_if.alpha_in    <= '0;
		pix_in_if.frame_start <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults straight out of reset: limits 10 and 3000, no mode bits.
		// Depths of zero, just below and on the low limit, and on and just above the high one.
		send_pixel(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(1'b0, 8'h00, 8'h09, 8'hFF, 8'hFF);
		send_pixel(1'b0, 8'h00, 8'h0A, 8'h5A, 8'hC3);
		send_pixel(1'b0, 8'h0B, 8'hB8, 8'hA5, 8'h3C);
		send_pixel(1'b0, 8'h0B, 8'hB9, 8'h00, 8'h7E);

		// Trim with user coloring on a tiny frame. A nonzero mark lets a
		// too-far pixel through the limit test but never a too-near one.
		apply_config(16'd10, 16'd3000, -16'sd2000, 16'sd2000, -16'sd2000, 16'sd2000,
			16'h000A, 16'd8);
		send_pixel(1'b1, 8'h0B, 8'hB9, 8'h00, 8'h11);
		send_pixel(1'b0, 8'h0B, 8'hB9, 8'h01, 8'h22);
		send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(1'b0, 8'h03, 8'hE8, 8'h80, 8'h00);
		send_pixel(1'b0, 8'h00, 8'h09, 8'hFF, 8'h33);
		send_pixel(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF);

		// Every mode bit, widest limits and widest box. The width word carries
		// stray upper bits and a low limit of zero lets depth zero pass.
		apply_config(16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h000F, 16'hF800);
		send_pixel(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(1'b0, 8'hFF, 8'hFF, 8'h00, 8'hFF);
		send_pixel(1'b0, 8'h00, 8'hFF, 8'hAA, 8'h55);
		send_pixel(1'b0, 8'hFF, 8'h00, 8'h55, 8'hAA);
		send_pixel(1'b0, 8'h0F, 8'hF0, 8'h01, 8'h80);

		// Crossed limits on a one-pixel-wide frame: nothing passes without a
		// mark. Invert and whitening, user coloring on via a padded mode word.
		apply_config(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFD, 16'd1);
		send_pixel(1'b1, 8'hFF, 8'hFF, 8'h00, 8'h10);
		send_pixel(1'b0, 8'hFF, 8'hFF, 8'h80, 8'h20);
		send_pixel(1'b0, 8'h00, 8'h64, 8'hFF, 8'h30);
		send_pixel(1'b0, 8'hFF, 8'hFE, 8'h01, 8'h40);

		// One long row with the width word beyond the largest frame: the
		// column climbs through the whole run without the row turning over.
		set_idling(0);
		apply_config(16'd0, 16'hFFFF, -16'sd3000, 16'sd3000, -16'sd1500, 16'sd1500,
			16'h0002, 16'h0FFF);
		send_random(250, 1'b0);

		// A zero width counts as one, so the row counter climbs every pixel
		// without a frame start.
		apply_config(16'd20, 16'd5000, -16'sd1000, 16'sd1000, -16'sd2500, 16'sd2500,
			16'h0003, 16'hF000);
		send_random(250, 1'b0);

		// Random settings under each idle pattern. One of the free-running
		// phases gets the long output hold-off so the block backs up and
		// stops taking pixels.
		for (int p = 0; p < 8; p++) begin
			random_config();
			set_idling(p % 4);
			if (p == 4)
				hold_asked++;
			send_random(70, 1'b1);
		end

		pix_in_if.valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (ledger.pending() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		ledger.report_leftovers();

		$display("Sent %0d pixels through %0d register settings (%0d register writes),",
			ledger.noted, settings, ledger.writes);
		$display("checked %0d output pixels, %0d mismatches.", ledger.checked,
			ledger.mismatches);
		if (ledger.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
